@@ design/spps_pkg.sv @@
// ----------------------------------------------------------------------------
// spps_pkg
// shared types, codes and constants of the softened pairwise potential sum
// ----------------------------------------------------------------------------
package spps_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;

	// one float operation per step of a pair
	typedef enum logic [3:0] {
		OP_SUBX,
		OP_SUBY,
		OP_SUBZ,
		OP_MULX,
		OP_MULY,
		OP_MULZ,
		OP_ADD1,
		OP_ADD2,
		OP_ADD3,
		OP_SQRT,
		OP_DIV,
		OP_ACC
	} op_t;

	typedef enum logic [1:0] {
		FN_ADD,
		FN_MUL,
		FN_DIV,
		FN_SQRT
	} fn_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_EXEC,
		ST_ITER,
		ST_NORM,
		ST_ALIGN,
		ST_ROUND,
		ST_WB,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic prep;
		logic exec;
		logic iter;
		logic norm;
		logic align;
		logic rnd;
		logic wb;
		logic emit;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic special;
		logic multi;
		logic iter_done;
		logic last;
	} status_t;

	function automatic fn_t op_fn(input op_t op);
		fn_t f;
		unique case (op)
			OP_SUBX, OP_SUBY, OP_SUBZ,
			OP_ADD1, OP_ADD2, OP_ADD3, OP_ACC: f = FN_ADD;
			OP_MULX, OP_MULY, OP_MULZ:         f = FN_MUL;
			OP_SQRT:                           f = FN_SQRT;
			OP_DIV:                            f = FN_DIV;
			default:                           f = FN_ADD;
		endcase
		return f;
	endfunction

endpackage

@@ design/softened_pairwise_potential_sum.sv @@
// ----------------------------------------------------------------------------
// softened_pairwise_potential_sum
// softened direct potential sum over target/source pairs in single precision
// ----------------------------------------------------------------------------
// usage
//   slave stream: one target/source pair per item; tuser flags the first pair
//   of a target (accumulator reloads from initial_potential), tlast the last
//   pair (one potential item goes out on the master stream)
//   per pair: dx, dy, dz, their squares, two sums, softening add, sqrt,
//   charge / r and the accumulate, each a separate rounded float operation
//   run one after another on a shared unit
//   add and multiply pass prep, exec, norm, align, round and write-back;
//   sqrt and divide add an iteration state in which the digit loop retires
//   one quotient or root bit a cycle, 28 bits; inf/nan/zero cases go from
//   prep straight to write-back; a new pair is taken only from idle, once the
//   last one is through; the output register holds the result while the
//   receiver stalls; the next pair is already taken and worked on, and waits
//   only at its own emit; reset clears the accumulator and softening_sq to
//   +0.0 and the sequencer to idle; the user writes softening_sq through
//   cfg_we/cfg_wdata, which the block does not check, only while idle
// ----------------------------------------------------------------------------
module softened_pairwise_potential_sum (
	input  logic         clk,
	input  logic         arst_n,
	// target_x, target_y, target_z, source_x, source_y, source_z,
	// source_charge, initial_potential (32 bits each, from bit 0 up)
	input  logic [255:0] s_tdata,
	// first_pair
	input  logic         s_tuser,
	input  logic         s_tlast,   // last_pair
	input  logic         s_tvalid,
	output logic         s_tready,
	// potential
	output logic [31:0]  m_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// softening_sq write
	input  logic         cfg_we,
	input  logic [31:0]  cfg_wdata
);
	import spps_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: one float operation at a time, phase strobes to the datapath
	spps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.m_tready (m_tready),
		.status   (status),
		.cmd      (cmd),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid)
	);

	// datapath: item registers, accumulator, float unit, output register
	spps_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.m_tdata   (m_tdata),
		.status    (status)
	);

endmodule

@@ design/spps_fpu.sv @@
// ----------------------------------------------------------------------------
// spps_fpu
// single-precision add, multiply, divide and square root, phase by phase
// ----------------------------------------------------------------------------
module spps_fpu (
	input  logic             clk,
	input  spps_pkg::cmd_t   cmd,
	input  spps_pkg::fn_t    fn,
	input  logic [31:0]      a,
	input  logic [31:0]      b,
	input  logic             neg_b,
	output logic [31:0]      res,
	output logic             special,
	output logic             iter_done
);
	import spps_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'd27;

	function automatic logic [4:0] clz24(input logic [23:0] v);
		logic [4:0] n;
		n = 5'd24;
		for (int i = 0; i < 24; i++) begin
			if (v[i]) n = 5'(23 - i);
		end
		return n;
	endfunction

	function automatic logic [4:0] clz28(input logic [27:0] v);
		logic [4:0] n;
		n = 5'd28;
		for (int i = 0; i < 28; i++) begin
			if (v[i]) n = 5'(27 - i);
		end
		return n;
	endfunction

	// ---------------- unpack and special cases
	logic [31:0] bx;
	logic sa, sb, nan_a, nan_b, inf_a, inf_b, zero_a, zero_b, swap;
	logic [7:0] xa, xb;
	logic [23:0] ma_raw, mb_raw, ma_nrm, mb_nrm;
	logic [4:0] lza, lzb;
	logic signed [10:0] ea_raw, eb_raw, ea_nrm, eb_nrm;
	logic spec_c;
	logic [31:0] spec_val;

	assign bx     = {b[31] ^ neg_b, b[30:0]};
	assign sa     = a[31];
	assign sb     = bx[31];
	assign xa     = a[30:23];
	assign xb     = bx[30:23];
	assign nan_a  = (xa == 8'hFF) && (a[22:0] != 23'd0);
	assign nan_b  = (xb == 8'hFF) && (bx[22:0] != 23'd0);
	assign inf_a  = (xa == 8'hFF) && (a[22:0] == 23'd0);
	assign inf_b  = (xb == 8'hFF) && (bx[22:0] == 23'd0);
	assign zero_a = (a[30:0] == 31'd0);
	assign zero_b = (bx[30:0] == 31'd0);
	assign ma_raw = {xa != 8'd0, a[22:0]};
	assign mb_raw = {xb != 8'd0, bx[22:0]};
	assign ea_raw = (xa == 8'd0) ? 11'sd1 : $signed({3'b000, xa});
	assign eb_raw = (xb == 8'd0) ? 11'sd1 : $signed({3'b000, xb});
	assign lza    = clz24(ma_raw);
	assign lzb    = clz24(mb_raw);
	assign ma_nrm = ma_raw << lza;
	assign mb_nrm = mb_raw << lzb;
	assign ea_nrm = ea_raw - $signed({6'b000000, lza});
	assign eb_nrm = eb_raw - $signed({6'b000000, lzb});
	assign swap   = bx[30:0] > a[30:0];

	always_comb begin
		spec_c   = 1'b0;
		spec_val = CANON_NAN;
		unique case (fn)
			FN_ADD: begin
				priority if (nan_a || nan_b) begin
					spec_c = 1'b1;
				end else if (inf_a && inf_b && (sa != sb)) begin
					spec_c = 1'b1;
				end else if (inf_a) begin
					spec_c = 1'b1; spec_val = {sa, 8'hFF, 23'd0};
				end else if (inf_b) begin
					spec_c = 1'b1; spec_val = {sb, 8'hFF, 23'd0};
				end
			end
			FN_MUL: begin
				priority if (nan_a || nan_b) begin
					spec_c = 1'b1;
				end else if ((inf_a && zero_b) || (zero_a && inf_b)) begin
					spec_c = 1'b1;
				end else if (inf_a || inf_b) begin
					spec_c = 1'b1; spec_val = {sa ^ sb, 8'hFF, 23'd0};
				end else if (zero_a || zero_b) begin
					spec_c = 1'b1; spec_val = {sa ^ sb, 31'd0};
				end
			end
			FN_DIV: begin
				priority if (nan_a || nan_b) begin
					spec_c = 1'b1;
				end else if (zero_b) begin
					spec_c = 1'b1;
					if (!zero_a) spec_val = {sa ^ sb, 8'hFF, 23'd0};
				end else if (inf_a && inf_b) begin
					spec_c = 1'b1;
				end else if (inf_a) begin
					spec_c = 1'b1; spec_val = {sa ^ sb, 8'hFF, 23'd0};
				end else if (inf_b || zero_a) begin
					spec_c = 1'b1; spec_val = {sa ^ sb, 31'd0};
				end
			end
			FN_SQRT: begin
				priority if (nan_a) begin
					spec_c = 1'b1;
				end else if (zero_a) begin
					spec_c = 1'b1; spec_val = a;
				end else if (sa) begin
					spec_c = 1'b1;
				end else if (inf_a) begin
					spec_c = 1'b1; spec_val = a;
				end
			end
			default: spec_c = 1'b0;
		endcase
	end

	assign special = spec_c;

	logic sa_q, sb_q, special_q;
	logic signed [10:0] ea_q, eb_q;
	logic [23:0] ma_q, mb_q;
	logic [31:0] spec_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			special_q <= spec_c;
			spec_q    <= spec_val;
			if (fn == FN_ADD) begin
				// larger magnitude goes first
				if (swap) begin
					sa_q <= sb; ea_q <= eb_raw; ma_q <= mb_raw;
					sb_q <= sa; eb_q <= ea_raw; mb_q <= ma_raw;
				end else begin
					sa_q <= sa; ea_q <= ea_raw; ma_q <= ma_raw;
					sb_q <= sb; eb_q <= eb_raw; mb_q <= mb_raw;
				end
			end else begin
				sa_q <= sa; ea_q <= ea_nrm; ma_q <= ma_nrm;
				sb_q <= sb; eb_q <= eb_nrm; mb_q <= mb_nrm;
			end
		end
	end

	// ---------------- execute: align and add, multiply, iteration setup
	logic signed [10:0] d, e_sq;
	logic [4:0] sh;
	logic [53:0] al_w;
	logic [27:0] op_a, op_b, sum;
	logic eff_sub;
	logic [24:0] m_sq;

	assign d       = ea_q - eb_q;
	assign sh      = (d > 11'sd27) ? 5'd27 : d[4:0];
	assign al_w    = {mb_q, 3'b000, 27'd0} >> sh;
	assign eff_sub = sa_q ^ sb_q;
	assign op_a    = {1'b0, ma_q, 3'b000};
	assign op_b    = {1'b0, al_w[53:28], al_w[27] | (|al_w[26:0])};
	assign sum     = eff_sub ? (op_a - op_b) : (op_a + op_b);
	assign e_sq    = ea_q - 11'sd127;
	assign m_sq    = e_sq[0] ? {ma_q, 1'b0} : {1'b0, ma_q};

	logic [27:0] pre_m_q, q_q;
	logic [47:0] prod_q;
	logic [31:0] rem_q;
	logic [55:0] rad_q;
	logic [4:0] cnt_q;
	logic signed [10:0] e_q;
	logic s_q;

	// iteration step of divide and square root
	logic [25:0] div_r;
	logic div_ge;
	logic [31:0] sq_rem, sq_trial;
	logic sq_ge;

	assign div_ge   = rem_q[25:0] >= {2'b00, mb_q};
	assign div_r    = div_ge ? (rem_q[25:0] - {2'b00, mb_q}) : rem_q[25:0];
	assign sq_rem   = {rem_q[29:0], rad_q[55:54]};
	assign sq_trial = {2'b00, q_q, 2'b01};
	assign sq_ge    = sq_rem >= sq_trial;
	assign iter_done = (cnt_q == 5'd0);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			unique case (fn)
				FN_ADD: begin
					pre_m_q <= sum;
					e_q     <= ea_q + 11'sd1;
					s_q     <= (eff_sub && (sum == 28'd0)) ? 1'b0 : sa_q;
				end
				FN_MUL: begin
					prod_q <= {24'd0, ma_q} * {24'd0, mb_q};
					e_q    <= ea_q + eb_q - 11'sd126;
					s_q    <= sa_q ^ sb_q;
				end
				FN_DIV: begin
					rem_q <= {8'd0, ma_q};
					q_q   <= 28'd0;
					cnt_q <= LAST_STEP;
					e_q   <= ea_q - eb_q + 11'sd127;
					s_q   <= sa_q ^ sb_q;
				end
				FN_SQRT: begin
					rad_q <= {m_sq, 31'd0};
					rem_q <= 32'd0;
					q_q   <= 28'd0;
					cnt_q <= LAST_STEP;
					e_q   <= (e_sq - $signed({10'd0, e_sq[0]})) >>> 1;
					s_q   <= 1'b0;
				end
				default: s_q <= 1'b0;
			endcase
		end else if (cmd.iter) begin
			cnt_q <= cnt_q - 5'd1;
			if (fn == FN_DIV) begin
				rem_q <= {5'd0, div_r, 1'b0};
				q_q   <= {q_q[26:0], div_ge};
			end else begin
				rem_q <= sq_ge ? (sq_rem - sq_trial) : sq_rem;
				q_q   <= {q_q[26:0], sq_ge};
				rad_q <= {rad_q[53:0], 2'b00};
			end
		end else if (cmd.norm && (fn == FN_SQRT)) begin
			// square root exponent gets its bias once the root is done
			e_q <= e_q + 11'sd127;
		end
	end

	// ---------------- normalize, denormal alignment, round
	logic [27:0] m_src;
	logic st_src;

	always_comb begin
		unique case (fn)
			FN_ADD:  begin m_src = pre_m_q;        st_src = 1'b0;              end
			FN_MUL:  begin m_src = prod_q[47:20];  st_src = |prod_q[19:0];     end
			default: begin m_src = q_q;            st_src = (rem_q != 32'd0);  end
		endcase
	end

	logic [27:0] n_m_q, a_m_q;
	logic n_st_q, a_st_q;
	logic [4:0] lz_q;
	logic signed [10:0] a_e_q;
	logic [31:0] rnd_q;

	logic signed [10:0] el, rsh;
	logic [4:0] rs;
	logic [59:0] rw;

	assign el  = e_q - $signed({6'b000000, lz_q});
	assign rsh = 11'sd1 - e_q;
	assign rs  = (rsh > 11'sd31) ? 5'd31 : rsh[4:0];
	assign rw  = {n_m_q, 32'd0} >> rs;

	logic [23:0] mant24, mant;
	logic [24:0] s25;
	logic g, st, inc;
	logic signed [10:0] er;

	assign mant24 = a_m_q[27:4];
	assign g      = a_m_q[3];
	assign st     = (|a_m_q[2:0]) | a_st_q;
	assign inc    = g & (st | mant24[0]);
	assign s25    = {1'b0, mant24} + {24'd0, inc};
	assign mant   = s25[24] ? s25[24:1] : s25[23:0];
	assign er     = a_e_q + $signed({10'd0, s25[24]});

	always_ff @(posedge clk) begin
		if (cmd.norm) begin
			n_m_q  <= m_src;
			n_st_q <= st_src;
			lz_q   <= clz28(m_src);
		end
		if (cmd.align) begin
			priority if (el >= 11'sd1) begin
				a_m_q  <= n_m_q << lz_q;
				a_st_q <= n_st_q;
				a_e_q  <= el;
			end else if (e_q >= 11'sd1) begin
				// result lands in the denormal range
				a_m_q  <= n_m_q << e_q[4:0] - 5'd1;
				a_st_q <= n_st_q;
				a_e_q  <= 11'sd1;
			end else begin
				a_m_q  <= rw[59:32];
				a_st_q <= n_st_q | (|rw[31:0]);
				a_e_q  <= 11'sd1;
			end
		end
		if (cmd.rnd) begin
			if (er >= 11'sd255) rnd_q <= {s_q, 8'hFF, 23'd0};
			else rnd_q <= {s_q, mant[23] ? er[7:0] : 8'h00, mant[22:0]};
		end
	end

	assign res = special_q ? spec_q : rnd_q;

endmodule

@@ design/spps_dp.sv @@
// ----------------------------------------------------------------------------
// spps_dp
// item and temporary registers, accumulator, operand selection, result register
// ----------------------------------------------------------------------------
module spps_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  spps_pkg::cmd_t    cmd,
	input  logic [255:0]      s_tdata,
	input  logic              s_tuser,
	input  logic              s_tlast,
	input  logic              cfg_we,
	input  logic [31:0]       cfg_wdata,
	output logic [31:0]       m_tdata,
	output spps_pkg::status_t status
);
	import spps_pkg::*;

	logic [31:0] tx_q, ty_q, tz_q, sx_q, sy_q, sz_q, chg_q;
	logic [31:0] dx_q, dy_q, dz_q, acc_q, soft_q, pot_q;
	logic last_q;
	logic [31:0] opa, opb, res;
	logic neg_b, fpu_special, fpu_done;
	fn_t fn;

	assign fn = op_fn(cmd.op);

	always_comb begin
		neg_b = 1'b0;
		unique case (cmd.op)
			OP_SUBX: begin opa = tx_q;  opb = sx_q;   neg_b = 1'b1; end
			OP_SUBY: begin opa = ty_q;  opb = sy_q;   neg_b = 1'b1; end
			OP_SUBZ: begin opa = tz_q;  opb = sz_q;   neg_b = 1'b1; end
			OP_MULX: begin opa = dx_q;  opb = dx_q;   end
			OP_MULY: begin opa = dy_q;  opb = dy_q;   end
			OP_MULZ: begin opa = dz_q;  opb = dz_q;   end
			OP_ADD1: begin opa = dx_q;  opb = dy_q;   end
			OP_ADD2: begin opa = dx_q;  opb = dz_q;   end
			OP_ADD3: begin opa = dx_q;  opb = soft_q; end
			OP_SQRT: begin opa = dx_q;  opb = dx_q;   end
			OP_DIV:  begin opa = chg_q; opb = dx_q;   end
			OP_ACC:  begin opa = acc_q; opb = dx_q;   end
			default: begin opa = dx_q;  opb = dx_q;   end
		endcase
	end

	spps_fpu u_fpu (
		.clk       (clk),
		.cmd       (cmd),
		.fn        (fn),
		.a         (opa),
		.b         (opb),
		.neg_b     (neg_b),
		.res       (res),
		.special   (fpu_special),
		.iter_done (fpu_done)
	);

	// item payload and temporaries
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			tx_q  <= s_tdata[31:0];
			ty_q  <= s_tdata[63:32];
			tz_q  <= s_tdata[95:64];
			sx_q  <= s_tdata[127:96];
			sy_q  <= s_tdata[159:128];
			sz_q  <= s_tdata[191:160];
			chg_q <= s_tdata[223:192];
		end
		if (cmd.wb) begin
			unique case (cmd.op)
				OP_SUBY, OP_MULY: dy_q <= res;
				OP_SUBZ, OP_MULZ: dz_q <= res;
				OP_ACC:           dz_q <= dz_q;
				default:          dx_q <= res;
			endcase
		end
		if (cmd.emit) begin
			pot_q <= ((acc_q[30:23] == 8'hFF) && (acc_q[22:0] != 23'd0)) ? CANON_NAN : acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= 32'd0;
			soft_q <= 32'd0;
			last_q <= 1'b0;
		end else begin
			if (cfg_we) soft_q <= cfg_wdata;
			if (cmd.load) begin
				last_q <= s_tlast;
				if (s_tuser) acc_q <= s_tdata[255:224];
			end else if (cmd.wb && (cmd.op == OP_ACC)) begin
				acc_q <= res;
			end
		end
	end

	assign m_tdata          = pot_q;
	assign status.special   = fpu_special;
	assign status.multi     = (fn == FN_DIV) || (fn == FN_SQRT);
	assign status.iter_done = fpu_done;
	assign status.last      = last_q;

endmodule

@@ design/spps_ctrl.sv @@
// ----------------------------------------------------------------------------
// spps_ctrl
// sequencer: steps through the float operations of one pair, phase by phase
// ----------------------------------------------------------------------------
module spps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              m_tready,
	input  spps_pkg::status_t status,
	output spps_pkg::cmd_t    cmd,
	output logic              s_tready,
	output logic              m_tvalid
);
	import spps_pkg::*;

	state_t state_q, state_d;
	op_t op_q;
	logic out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (s_tvalid) state_d = ST_PREP;
			ST_PREP:  state_d = status.special ? ST_WB : ST_EXEC;
			ST_EXEC:  state_d = status.multi ? ST_ITER : ST_NORM;
			ST_ITER:  if (status.iter_done) state_d = ST_NORM;
			ST_NORM:  state_d = ST_ALIGN;
			ST_ALIGN: state_d = ST_ROUND;
			ST_ROUND: state_d = ST_WB;
			ST_WB: begin
				if (op_q != OP_ACC) state_d = ST_PREP;
				else state_d = status.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT:  if (!out_valid_q || m_tready) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd       = '0;
		cmd.op    = op_q;
		s_tready  = (state_q == ST_IDLE);
		cmd.load  = s_tready && s_tvalid;
		cmd.prep  = (state_q == ST_PREP);
		cmd.exec  = (state_q == ST_EXEC);
		cmd.iter  = (state_q == ST_ITER);
		cmd.norm  = (state_q == ST_NORM);
		cmd.align = (state_q == ST_ALIGN);
		cmd.rnd   = (state_q == ST_ROUND);
		cmd.wb    = (state_q == ST_WB);
		cmd.emit  = (state_q == ST_EMIT) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SUBX;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) op_q <= OP_SUBX;
			else if (cmd.wb && (op_q != OP_ACC)) op_q <= op_t'(op_q + 4'd1);
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ design/spps_chk.sv @@
// ----------------------------------------------------------------------------
// spps_chk
// port-level checks of the potential sum, bound to the top level
// ----------------------------------------------------------------------------
module spps_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] m_tdata,
	input logic        m_tvalid,
	input logic        m_tready
);
	import spps_pkg::*;

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// one pair at a time: no accept in the cycle after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item accepted while busy");

	// a result never follows an accept in the next cycle
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result too early");

	// nan results are canonical
	a_nan: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !((m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0))
			|| (m_tdata == CANON_NAN))
		else $error("non-canonical nan");

endmodule

bind softened_pairwise_potential_sum spps_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

@@ dv/tb_softened_pairwise_potential_sum.sv @@
// ----------------------------------------------------------------------------
// tb_softened_pairwise_potential_sum
// self-checking bench for the softened pairwise potential sum
// ----------------------------------------------------------------------------
// target/source pair items go in through a queue-fed driver, potential items
// are checked by a monitor against a bit-exact single-precision predictor
// built from integer arithmetic; softening_sq is swept through several
// settings between phases while the block is idle, and both streams stall in
// random bursts except in the last phase
// ----------------------------------------------------------------------------
module tb_softened_pairwise_potential_sum;
	import spps_pkg::*;

	typedef struct {
		logic [31:0] tx, ty, tz, sx, sy, sz, chg, init;
		logic        first, last;
	} pair_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic [255:0] s_tdata = '0;
	logic         s_tuser = 1'b0;
	logic         s_tlast = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [31:0]  m_tdata;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic         cfg_we = 1'b0;
	logic [31:0]  cfg_wdata = '0;

	pair_t       pending_pairs[$];
	logic [31:0] expected_potential[$];
	logic [31:0] model_acc;
	logic [31:0] model_soft;
	int          mismatches = 0;
	bit          quiet = 1'b0;
	int          in_idle = 0;
	int          out_idle = 0;

	softened_pairwise_potential_sum DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.m_tdata   (m_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// float helpers on bit patterns, round to nearest even, no ftz
	// ---------------------------------------------------------------------
	function automatic bit f_nan(logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != 0;
	endfunction

	function automatic bit f_inf(logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] == 0;
	endfunction

	function automatic bit f_zero(logic [31:0] b);
		return b[30:0] == 0;
	endfunction

	// finite nonzero value = m * 2^e with m normalized to bit 23
	function automatic void f_unpack(input logic [31:0] b, output int e,
			output logic [63:0] m);
		if (b[30:23] == 0) begin
			m = {41'b0, b[22:0]};
			e = -149;
			while (!m[23]) begin
				m = m << 1;
				e--;
			end
		end else begin
			m = {40'b0, 1'b1, b[22:0]};
			e = int'(b[30:23]) - 150;
		end
	endfunction

	// round sign * m * 2^e to single precision, gradual underflow
	function automatic logic [31:0] f_round(logic sgn, int e, logic [63:0] m);
		int k, ex, lsb, sh, be;
		logic [63:0] q;
		logic g, st;
		if (m == 0) return {sgn, 31'b0};
		k = 63;
		while (!m[k]) k--;
		ex = k + e;
		lsb = (ex < -126) ? -149 : ex - 23;
		sh = lsb - e;
		if (sh > 64) begin
			q = 0; g = 1'b0; st = 1'b1;
		end else if (sh == 64) begin
			q = 0; g = m[63]; st = (m << 1) != 0;
		end else if (sh > 0) begin
			q = m >> sh;
			g = m[sh-1];
			st = (m & ((64'h1 << (sh - 1)) - 1)) != 0;
		end else begin
			q = m << (-sh); g = 1'b0; st = 1'b0;
		end
		if (g && (st || q[0])) q++;
		if (q[24]) begin
			q = q >> 1;
			lsb++;
		end
		if (q == 0) return {sgn, 31'b0};
		be = q[23] ? lsb + 150 : 0;
		if (be >= 255) return {sgn, 8'hFF, 23'b0};
		return {sgn, be[7:0], q[22:0]};
	endfunction

	function automatic logic [31:0] f_add(logic [31:0] a, logic [31:0] b);
		int ea, eb, e, d;
		logic [63:0] ma, mb, m;
		logic sa, sb, s;
		if (f_nan(a) || f_nan(b)) return CANON_NAN;
		if (f_inf(a) && f_inf(b)) return (a[31] != b[31]) ? CANON_NAN : a;
		if (f_inf(a)) return a;
		if (f_inf(b)) return b;
		if (f_zero(a) && f_zero(b)) return {a[31] & b[31], 31'b0};
		if (f_zero(a)) return b;
		if (f_zero(b)) return a;
		f_unpack(a, ea, ma);
		f_unpack(b, eb, mb);
		sa = a[31];
		sb = b[31];
		if (ea < eb) begin
			{ea, eb} = {eb, ea};
			{ma, mb} = {mb, ma};
			{sa, sb} = {sb, sa};
		end
		d = ea - eb;
		// far smaller operand only matters as a sticky bit below the guard
		if (d > 30) begin
			ma = ma << 3; mb = 1; e = ea - 3;
		end else begin
			ma = ma << d; e = eb;
		end
		if (sa == sb) begin
			m = ma + mb; s = sa;
		end else if (ma >= mb) begin
			m = ma - mb; s = sa;
		end else begin
			m = mb - ma; s = sb;
		end
		if (m == 0) return 32'h0;
		return f_round(s, e, m);
	endfunction

	function automatic logic [31:0] f_mul(logic [31:0] a, logic [31:0] b);
		int ea, eb;
		logic [63:0] ma, mb;
		logic s;
		s = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) return CANON_NAN;
		if ((f_inf(a) && f_zero(b)) || (f_zero(a) && f_inf(b))) return CANON_NAN;
		if (f_inf(a) || f_inf(b)) return {s, 8'hFF, 23'b0};
		if (f_zero(a) || f_zero(b)) return {s, 31'b0};
		f_unpack(a, ea, ma);
		f_unpack(b, eb, mb);
		return f_round(s, ea + eb, ma * mb);
	endfunction

	// charge / r, a zero r gives a signed infinity unless charge is zero
	function automatic logic [31:0] f_div(logic [31:0] a, logic [31:0] b);
		int ea, eb;
		logic [63:0] ma, mb;
		logic [127:0] n, qq, rm;
		logic s;
		s = a[31] ^ b[31];
		if (f_nan(a) || f_nan(b)) return CANON_NAN;
		if (f_zero(b)) return f_zero(a) ? CANON_NAN : {s, 8'hFF, 23'b0};
		if (f_inf(a) && f_inf(b)) return CANON_NAN;
		if (f_inf(a)) return {s, 8'hFF, 23'b0};
		if (f_inf(b) || f_zero(a)) return {s, 31'b0};
		f_unpack(a, ea, ma);
		f_unpack(b, eb, mb);
		n = {64'b0, ma} << 40;
		qq = n / mb;
		rm = n % mb;
		return f_round(s, ea - eb - 41, {qq[62:0], rm != 0});
	endfunction

	function automatic logic [31:0] f_sqrt(logic [31:0] b);
		int e;
		logic [63:0] m;
		logic [127:0] v, r, c;
		if (f_nan(b)) return CANON_NAN;
		if (f_zero(b)) return b;
		if (b[31]) return CANON_NAN;
		if (f_inf(b)) return b;
		f_unpack(b, e, m);
		if (e % 2 != 0) begin
			m = m << 1;
			e--;
		end
		v = {64'b0, m} << 50;
		r = 0;
		for (int i = 40; i >= 0; i--) begin
			c = r | (128'h1 << i);
			if (c * c <= v) r = c;
		end
		return f_round(1'b0, (e - 50) / 2 - 1, {r[62:0], r * r != v});
	endfunction

	// ---------------------------------------------------------------------
	// potential predictor: one accepted pair, at most one potential item
	// ---------------------------------------------------------------------
	task automatic predict_pair(pair_t p);
		logic [31:0] dx, dy, dz, sum, r;
		if (p.first) model_acc = p.init;
		dx = f_add(p.tx, {~p.sx[31], p.sx[30:0]});
		dy = f_add(p.ty, {~p.sy[31], p.sy[30:0]});
		dz = f_add(p.tz, {~p.sz[31], p.sz[30:0]});
		sum = f_add(f_mul(dx, dx), f_mul(dy, dy));
		sum = f_add(sum, f_mul(dz, dz));
		sum = f_add(sum, model_soft);
		r = f_sqrt(sum);
		model_acc = f_add(model_acc, f_div(p.chg, r));
		if (p.last) expected_potential.push_back(f_nan(model_acc) ? CANON_NAN : model_acc);
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %08h want %08h", $realtime, what, got, want);
		mismatches++;
	endtask

	// ---------------------------------------------------------------------
	// driver: pairs from the pending queue, idle bursts between items
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		pair_t p;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				p.tx = s_tdata[31:0];    p.ty = s_tdata[63:32];
				p.tz = s_tdata[95:64];   p.sx = s_tdata[127:96];
				p.sy = s_tdata[159:128]; p.sz = s_tdata[191:160];
				p.chg = s_tdata[223:192]; p.init = s_tdata[255:224];
				p.first = s_tuser;
				p.last = s_tlast;
				predict_pair(p);
			end
			if (!s_tvalid || s_tready) begin
				if (in_idle > 0) begin
					in_idle--;
					s_tvalid <= 1'b0;
				end else if (pending_pairs.size() != 0 && !quiet
						&& $urandom_range(0, 9) == 0) begin
					in_idle = $urandom_range(0, 11);
					s_tvalid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					p = pending_pairs.pop_front();
					s_tdata <= {p.init, p.chg, p.sz, p.sy, p.sx, p.tz, p.ty, p.tx};
					s_tuser <= p.first;
					s_tlast <= p.last;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// monitor: receiver stalls and the potential check
	// ---------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_potential.size() == 0)
					report_mismatch("unexpected potential", m_tdata, 32'h0);
				else if (m_tdata !== expected_potential[0])
					report_mismatch("potential", m_tdata, expected_potential.pop_front());
				else
					void'(expected_potential.pop_front());
			end
			if (out_idle > 0) begin
				out_idle--;
				m_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_idle = $urandom_range(0, 11);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------
	// stimulus
	// ---------------------------------------------------------------------
	function automatic logic [31:0] rand_val();
		logic [31:0] specials[9] = '{32'h0, 32'h8000_0000, 32'h7F80_0000,
			32'hFF80_0000, 32'h7FC0_0000, 32'h7F7F_FFFF, 32'h0000_0001,
			32'h007F_FFFF, 32'h0080_0000};
		logic [7:0] ex;
		case ($urandom_range(0, 9))
			0, 1:    return $urandom;
			2:       return specials[$urandom_range(0, 8)];
			default: begin
				ex = 8'($urandom_range(117, 137));
				return {1'($urandom), ex, 23'($urandom)};
			end
		endcase
	endfunction

	task automatic push_pair(logic [31:0] tx, ty, tz, sx, sy, sz, chg, init,
			logic first, logic last);
		pair_t p;
		p.tx = tx; p.ty = ty; p.tz = tz;
		p.sx = sx; p.sy = sy; p.sz = sz;
		p.chg = chg; p.init = init;
		p.first = first;
		p.last = last;
		pending_pairs.push_back(p);
	endtask

	// mostly whole targets (first ... last), some loose pairs with random flags
	task automatic add_random_pairs(int n);
		int made, len;
		logic [31:0] tx, ty, tz;
		made = 0;
		while (made < n) begin
			if ($urandom_range(0, 9) == 0) begin
				push_pair(rand_val(), rand_val(), rand_val(), rand_val(), rand_val(),
					rand_val(), rand_val(), rand_val(), 1'($urandom), 1'($urandom));
				made++;
			end else begin
				len = $urandom_range(1, 6);
				tx = rand_val(); ty = rand_val(); tz = rand_val();
				for (int i = 0; i < len; i++) begin
					// sometimes a source on top of its target, r is then zero
					if ($urandom_range(0, 9) == 0)
						push_pair(tx, ty, tz, tx, ty, tz, rand_val(), rand_val(),
							i == 0, i == len - 1);
					else
						push_pair(tx, ty, tz, rand_val(), rand_val(), rand_val(),
							rand_val(), rand_val(), i == 0, i == len - 1);
				end
				made += len;
			end
		end
	endtask

	// sender holds off until every potential is back, then lets the pipe settle
	task automatic drain();
		while (pending_pairs.size() != 0 || s_tvalid || expected_potential.size() != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_softening(logic [31:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_soft = v;
	endtask

	initial begin
		logic [31:0] settings[9];
		settings = '{32'h3F80_0000, 32'h7F7F_FFFF, 32'h0000_0001, 32'hBF80_0000,
			32'h8000_0000, 32'h7F80_0000, 32'hFFFF_FFFF, 32'h0, 32'h0};
		settings[7] = $urandom;
		model_acc = 32'h0;
		model_soft = 32'h0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// accumulator not reloaded after reset, starts from +0.0
		push_pair(32'h3F80_0000, 0, 0, 0, 0, 0, 32'h3F80_0000, 32'h4000_0000, 0, 1);
		// both flags on one pair
		push_pair(32'h4040_0000, 32'h3F00_0000, 32'hC000_0000, 32'h3F80_0000,
			32'hBF80_0000, 32'h4100_0000, 32'h4000_0000, 32'h4000_0000, 1, 1);
		// zero r with positive, negative and zero charge
		push_pair(32'h4120_0000, 32'h4120_0000, 32'h4120_0000, 32'h4120_0000,
			32'h4120_0000, 32'h4120_0000, 32'h3F80_0000, 0, 1, 1);
		push_pair(32'h4120_0000, 32'h4120_0000, 32'h4120_0000, 32'h4120_0000,
			32'h4120_0000, 32'h4120_0000, 32'hBF80_0000, 0, 1, 1);
		push_pair(32'h4120_0000, 32'h4120_0000, 32'h4120_0000, 32'h4120_0000,
			32'h4120_0000, 32'h4120_0000, 32'h8000_0000, 0, 1, 1);
		// all fields at zero, then all ones
		push_pair(0, 0, 0, 0, 0, 0, 0, 0, 1, 1);
		push_pair('1, '1, '1, '1, '1, '1, '1, '1, 1, 1);
		// largest finite coordinates, distance overflows
		push_pair(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'hFF7F_FFFF,
			32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 1, 1);
		// infinite coordinates on both bodies
		push_pair(32'h7F80_0000, 0, 0, 32'h7F80_0000, 0, 0, 32'h3F80_0000, 0, 1, 1);
		// subnormal distances
		push_pair(32'h0000_0001, 32'h007F_FFFF, 0, 32'h8000_0001, 0, 32'h0000_0001,
			32'h0000_0001, 32'h8000_0000, 1, 1);
		// one target over four sources
		push_pair(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 0, 0, 0,
			32'h3F80_0000, 32'hC080_0000, 1, 0);
		push_pair(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4100_0000,
			32'hC100_0000, 32'h3E80_0000, 32'h4080_0000, 0, 0, 0);
		push_pair(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h3F80_0000,
			32'h4000_0000, 32'h4040_0000, 32'h3F80_0000, 0, 0, 0);
		push_pair(32'h3F80_0000, 32'h4000_0000, 32'h4040_0000, 32'h4480_0000,
			0, 0, 32'hFF7F_FFFF, 0, 0, 1);
		// nan payloads in start value and charge come out canonical
		push_pair(0, 0, 0, 32'h3F80_0000, 0, 0, 32'h3F80_0000, 32'h7FC0_0001, 1, 1);
		push_pair(0, 0, 0, 32'h3F80_0000, 0, 0, 32'hFFC1_2345, 0, 1, 1);
		drain();

		foreach (settings[i]) begin
			write_softening(settings[i]);
			if (i == 8) quiet = 1'b1;
			add_random_pairs(160);
			drain();
		end

		while (expected_potential.size() != 0)
			report_mismatch("missing potential", 32'h0, expected_potential.pop_front());
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#(20 * 3_000_000);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ filelist.f @@
design/spps_pkg.sv
design/spps_fpu.sv
design/spps_dp.sv
design/spps_ctrl.sv
design/softened_pairwise_potential_sum.sv
design/spps_chk.sv
dv/tb_softened_pairwise_potential_sum.sv
